/* rtl/srb_pkg.sv */
`default_nettype none

package srb_pkg;

   // Reorder window: slots of parked descriptors, one per sequence modulo WINDOW.
   localparam int unsigned WINDOW      = 32;
   localparam int unsigned IDX_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int unsigned MAX_RESULTS = 32;
   localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam int unsigned SEQ_W   = 64;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned TAG_W   = 16;
   localparam int unsigned TOTAL_W = 64;
   localparam int unsigned DESC_W  = LEN_W + TAG_W;

   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [1:0] {
      STAT_DELIVERED = 2'd0,
      STAT_PARKED    = 2'd1,
      STAT_DUPLICATE = 2'd2,
      STAT_BEYOND    = 2'd3
   } status_type;

   typedef struct packed {
      status_type         status;
      logic [SEQ_W-1:0]   seq;
      logic [LEN_W-1:0]   len;
      logic [TAG_W-1:0]   tag;
      logic               last;
      logic [TOTAL_W-1:0] packets;
      logic [TOTAL_W-1:0] bytes;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      idx_type           wr_addr;
      logic              wr_valid;
      logic              desc_wr_en;
      logic [DESC_W-1:0] desc_data;
      logic              rd_en;
      idx_type           rd_addr;
   } mem_req_type;

endpackage

`default_nettype wire

/* rtl/srb_slot_store.sv */
`default_nettype none

module srb_slot_store (
   input  wire logic                        clock,
   input  wire srb_pkg::mem_req_type        mem_req,
   output logic                             rd_valid,
   output logic [srb_pkg::DESC_W-1:0]       rd_desc
);

   // Slot valid flags and parked descriptors, one synchronous read port each.
   logic                       valid_mem [srb_pkg::WINDOW];
   logic [srb_pkg::DESC_W-1:0] desc_mem  [srb_pkg::WINDOW];

   logic                       rd_valid_ff;
   logic [srb_pkg::DESC_W-1:0] rd_desc_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         valid_mem[mem_req.wr_addr] <= mem_req.wr_valid;
      end
      if (mem_req.rd_en) begin
         rd_valid_ff <= valid_mem[mem_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.desc_wr_en) begin
         desc_mem[mem_req.wr_addr] <= mem_req.desc_data;
      end
      if (mem_req.rd_en) begin
         rd_desc_ff <= desc_mem[mem_req.rd_addr];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_desc  = rd_desc_ff;

endmodule

`default_nettype wire

/* rtl/srb_out_stage.sv */
`default_nettype none

module srb_out_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire srb_pkg::rsp_type push_data,
   output logic                  free,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [223:0]          rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   logic             valid_ff;
   logic             valid_in;
   srb_pkg::rsp_type data_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = push || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {data_ff.bytes, data_ff.packets, data_ff.tag, data_ff.len, data_ff.seq};
   assign rsp_tuser  = data_ff.status;
   assign rsp_tlast  = data_ff.last;

endmodule

`default_nettype wire

/* rtl/srb_ctrl.sv */
`default_nettype none

module srb_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [srb_pkg::SEQ_W-1:0]    req_seq,
   input  wire logic [srb_pkg::LEN_W-1:0]    req_len,
   input  wire logic [srb_pkg::TAG_W-1:0]    req_tag,
   output srb_pkg::mem_req_type              mem_req,
   input  wire logic                         rd_valid,
   input  wire logic [srb_pkg::DESC_W-1:0]   rd_desc,
   input  wire logic                         out_free,
   output logic                              push,
   output srb_pkg::rsp_type                  push_data
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_EVAL  = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   localparam srb_pkg::idx_type LAST_IDX = srb_pkg::IDX_W'(srb_pkg::WINDOW - 1);

   // Slot of the sequence after e; the index restarts where the sequence wraps.
   function automatic srb_pkg::idx_type next_idx(logic [srb_pkg::SEQ_W-1:0] e,
                                                 srb_pkg::idx_type i);
      srb_pkg::idx_type r;
      if (&e || i == LAST_IDX) begin
         r = '0;
      end else begin
         r = i + srb_pkg::IDX_W'(1);
      end
      return r;
   endfunction

   state_type                     state_ff, state_in;
   srb_pkg::idx_type              clr_ff, clr_in;
   logic [srb_pkg::SEQ_W-1:0]     seq_ff;
   logic [srb_pkg::LEN_W-1:0]     len_ff;
   logic [srb_pkg::TAG_W-1:0]     tag_ff;
   logic [srb_pkg::SEQ_W-1:0]     exp_ff, exp_in;
   srb_pkg::idx_type              exp_idx_ff, exp_idx_in;
   logic [srb_pkg::TOTAL_W-1:0]   pkt_ff, pkt_in;
   logic [srb_pkg::TOTAL_W-1:0]   byte_ff, byte_in;
   logic [srb_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   srb_pkg::rsp_type              pend_ff, pend_in;

   logic                          accept;
   logic [srb_pkg::SEQ_W:0]       diff;
   srb_pkg::status_type           eval_status;
   logic [srb_pkg::IDX_W:0]       slot_sum;
   srb_pkg::idx_type              park_slot;
   logic                          more;
   logic [srb_pkg::LEN_W-1:0]     rd_len;
   logic [srb_pkg::TAG_W-1:0]     rd_tag;

   assign rd_len = rd_desc[srb_pkg::DESC_W-1:srb_pkg::TAG_W];
   assign rd_tag = rd_desc[srb_pkg::TAG_W-1:0];

   // Classify the arriving packet against the expected sequence.
   always_comb begin
      diff     = {1'b0, seq_ff} - {1'b0, exp_ff};
      slot_sum = {1'b0, exp_idx_ff} + {1'b0, diff[srb_pkg::IDX_W-1:0]};
      if (slot_sum >= (srb_pkg::IDX_W + 1)'(srb_pkg::WINDOW)) begin
         park_slot = srb_pkg::IDX_W'(slot_sum - (srb_pkg::IDX_W + 1)'(srb_pkg::WINDOW));
      end else begin
         park_slot = slot_sum[srb_pkg::IDX_W-1:0];
      end
      priority if (diff == '0) begin
         eval_status = srb_pkg::STAT_DELIVERED;
      end else if (diff[srb_pkg::SEQ_W]) begin
         eval_status = srb_pkg::STAT_DUPLICATE;
      end else if (diff[srb_pkg::SEQ_W-1:0] < srb_pkg::SEQ_W'(srb_pkg::WINDOW)) begin
         eval_status = srb_pkg::STAT_PARKED;
      end else begin
         eval_status = srb_pkg::STAT_BEYOND;
      end
   end

   assign more       = rd_valid && (cnt_ff < srb_pkg::CNT_W'(srb_pkg::MAX_RESULTS));
   assign req_tready = (state_ff == ST_IDLE) || (state_ff == ST_DRAIN && !more && out_free);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      exp_in     = exp_ff;
      exp_idx_in = exp_idx_ff;
      pkt_in     = pkt_ff;
      byte_in    = byte_ff;
      cnt_in     = cnt_ff;
      pend_in    = pend_ff;
      push       = 1'b0;
      push_data  = pend_ff;
      mem_req    = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep the valid flags to zero, one slot a cycle.
            mem_req.wr_en    = 1'b1;
            mem_req.wr_addr  = clr_ff;
            mem_req.wr_valid = 1'b0;
            clr_in           = clr_ff + srb_pkg::IDX_W'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            pend_in.status  = eval_status;
            pend_in.seq     = seq_ff;
            pend_in.len     = len_ff;
            pend_in.tag     = tag_ff;
            pend_in.last    = 1'b0;
            pend_in.packets = pkt_ff;
            pend_in.bytes   = byte_ff;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = exp_idx_ff;
            cnt_in          = srb_pkg::CNT_W'(1);
            state_in        = ST_DRAIN;
            unique case (eval_status)
               srb_pkg::STAT_DELIVERED: begin
                  pkt_in           = pkt_ff + srb_pkg::TOTAL_W'(1);
                  byte_in          = byte_ff + srb_pkg::TOTAL_W'(len_ff);
                  exp_in           = exp_ff + srb_pkg::SEQ_W'(1);
                  exp_idx_in       = next_idx(exp_ff, exp_idx_ff);
                  pend_in.packets  = pkt_in;
                  pend_in.bytes    = byte_in;
                  mem_req.wr_en    = 1'b1;
                  mem_req.wr_addr  = exp_idx_ff;
                  mem_req.wr_valid = 1'b0;
                  mem_req.rd_addr  = exp_idx_in;
               end
               srb_pkg::STAT_PARKED: begin
                  mem_req.wr_en      = 1'b1;
                  mem_req.wr_addr    = park_slot;
                  mem_req.wr_valid   = 1'b1;
                  mem_req.desc_wr_en = 1'b1;
                  mem_req.desc_data  = {len_ff, tag_ff};
               end
               default: begin
               end
            endcase
         end
         ST_DRAIN: begin
            if (out_free) begin
               push           = 1'b1;
               push_data.last = !more;
               if (more) begin
                  // Release the parked packet at the expected sequence.
                  pkt_in           = pkt_ff + srb_pkg::TOTAL_W'(1);
                  byte_in          = byte_ff + srb_pkg::TOTAL_W'(rd_len);
                  exp_in           = exp_ff + srb_pkg::SEQ_W'(1);
                  exp_idx_in       = next_idx(exp_ff, exp_idx_ff);
                  pend_in.status   = srb_pkg::STAT_DELIVERED;
                  pend_in.seq      = exp_ff;
                  pend_in.len      = rd_len;
                  pend_in.tag      = rd_tag;
                  pend_in.last     = 1'b0;
                  pend_in.packets  = pkt_in;
                  pend_in.bytes    = byte_in;
                  mem_req.wr_en    = 1'b1;
                  mem_req.wr_addr  = exp_idx_ff;
                  mem_req.wr_valid = 1'b0;
                  mem_req.rd_en    = 1'b1;
                  mem_req.rd_addr  = exp_idx_in;
                  cnt_in           = cnt_ff + srb_pkg::CNT_W'(1);
               end else if (accept) begin
                  state_in = ST_EVAL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         exp_ff     <= '0;
         exp_idx_ff <= '0;
         pkt_ff     <= '0;
         byte_ff    <= '0;
         cnt_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         exp_ff     <= exp_in;
         exp_idx_ff <= exp_idx_in;
         pkt_ff     <= pkt_in;
         byte_ff    <= byte_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (accept) begin
         seq_ff <= req_seq;
         len_ff <= req_len;
         tag_ff <= req_tag;
      end
   end

   a_idx_in_window: assert property (@(posedge clock) disable iff (reset)
      exp_idx_ff <= LAST_IDX)
      else $error("expected slot index outside window");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= srb_pkg::CNT_W'(srb_pkg::MAX_RESULTS))
      else $error("result count beyond limit");

   a_direct_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && eval_status == srb_pkg::STAT_DELIVERED)
      |=> (exp_ff == $past(exp_ff) + srb_pkg::SEQ_W'(1)))
      else $error("direct delivery did not advance expected sequence");

   a_push_when_free: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result pushed into a full output register");

endmodule

`default_nettype wire

/* rtl/sequence_reorder_buffer.sv */
`default_nettype none

// Sequence reorder buffer: takes one packet descriptor per req transfer and
// returns one or more rsp transfers. The arriving packet's own result comes
// first (tuser: 0 delivered, 1 parked, 2 duplicate dropped, 3 beyond window
// dropped), followed by the parked packets that have now come into order, each
// as delivered, up to MAX_RESULTS results per input; tlast marks the final
// result for that input. Each result carries the delivered packet and byte
// totals after it. A packet is classified and the slot memory updated in the
// EVAL state; the slot memory is then read at the next expected sequence, and
// each drained packet takes one more registered read of that single read port.
// After reset the block clears all WINDOW slots (32 by default) of the slot
// valid memory and holds req_tready low meanwhile.
module sequence_reorder_buffer (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [95:0]  req_tdata,   // seq_number[63:0], payload_length[79:64],
                                          // buffer_tag[95:80]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [223:0]      rsp_tdata,   // out_seq[63:0], out_length[79:64],
                                          // out_tag[95:80], delivered_packets[159:96],
                                          // delivered_bytes[223:160]
   output logic [1:0]        rsp_tuser,   // status[1:0]
   output logic              rsp_tlast    // last
);

   srb_pkg::mem_req_type       mem_req;
   logic                       rd_valid;
   logic [srb_pkg::DESC_W-1:0] rd_desc;
   logic                       out_free;
   logic                       push;
   srb_pkg::rsp_type           push_data;

   // Sequencer: classify, park, and drain in order.
   srb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_seq    (req_tdata[63:0]),
      .req_len    (req_tdata[79:64]),
      .req_tag    (req_tdata[95:80]),
      .mem_req    (mem_req),
      .rd_valid   (rd_valid),
      .rd_desc    (rd_desc),
      .out_free   (out_free),
      .push       (push),
      .push_data  (push_data)
   );

   // Slot memories: valid flags and parked descriptors.
   srb_slot_store u_store (
      .clock    (clock),
      .mem_req  (mem_req),
      .rd_valid (rd_valid),
      .rd_desc  (rd_desc)
   );

   // Output register: hold a result until the sink takes the transfer.
   srb_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* dv/tb_sequence_reorder_buffer.sv */
`timescale 1ns / 100ps

module tb_sequence_reorder_buffer;

   localparam int CLK_PERIOD      = 8;
   localparam int RANDOM_ITEMS    = 420;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 60;

   // Packet descriptor laid out as on req_tdata: seq in the low bits.
   typedef struct packed {
      logic [srb_pkg::TAG_W-1:0] tag;
      logic [srb_pkg::LEN_W-1:0] len;
      logic [srb_pkg::SEQ_W-1:0] seq;
   } pkt_desc_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [223:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;

   // Shadow of the reorder state: next in-order sequence, parked slots, totals.
   logic [srb_pkg::SEQ_W-1:0]   next_seq;
   logic                        parked_valid [srb_pkg::WINDOW];
   logic [srb_pkg::LEN_W-1:0]   parked_len [srb_pkg::WINDOW];
   logic [srb_pkg::TAG_W-1:0]   parked_tag [srb_pkg::WINDOW];
   logic [srb_pkg::TOTAL_W-1:0] packets_delivered;
   logic [srb_pkg::TOTAL_W-1:0] bytes_delivered;

   srb_pkg::rsp_type expected_rsp_q [$];
   pkt_desc_type     pending_q [$];
   int               error_count    = 0;
   int               accepted_count = 0;

   logic req_fire   = 1'b0;
   logic hold_off   = 1'b0;
   int   req_gap       = 0;
   int   req_mode_left = 0;
   bit   req_steady    = 1'b0;
   int   rsp_stall     = 0;
   int   rsp_mode_left = 0;
   bit   rsp_steady    = 1'b0;

   sequence_reorder_buffer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic report_error(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         report_error($sformatf("%s: got %h, expected %h", name, got, want));
   endtask

   task automatic queue_packet(logic [srb_pkg::SEQ_W-1:0] seq,
                               logic [srb_pkg::LEN_W-1:0] len,
                               logic [srb_pkg::TAG_W-1:0] tag);
      pending_q.push_back({tag, len, seq});
   endtask

   // Mostly random values, with the all-zero and all-one extremes mixed in.
   function automatic logic [15:0] pick_field16();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 16'h0000;
      if (r == 1)
         return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap(bit steady);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 50)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Classify one accepted packet, then release the parked packets that are now
   // in order, up to MAX_RESULTS results; queue the results, tlast on the final one.
   function automatic void reorder_packet(pkt_desc_type pkt);
      srb_pkg::rsp_type          r;
      logic [srb_pkg::SEQ_W-1:0] seq_gap;
      int unsigned               slot;
      int                        n;
      seq_gap = pkt.seq - next_seq;
      r.seq   = pkt.seq;
      r.len   = pkt.len;
      r.tag   = pkt.tag;
      r.last  = 1'b0;
      if (pkt.seq == next_seq) begin
         parked_valid[pkt.seq % srb_pkg::WINDOW] = 1'b0;
         packets_delivered += 1;
         bytes_delivered   += pkt.len;
         next_seq          += 1;
         r.status = srb_pkg::STAT_DELIVERED;
      end else if (pkt.seq > next_seq && seq_gap < srb_pkg::WINDOW) begin
         slot = 32'(pkt.seq % srb_pkg::WINDOW);
         parked_valid[slot] = 1'b1;
         parked_len[slot]   = pkt.len;
         parked_tag[slot]   = pkt.tag;
         r.status = srb_pkg::STAT_PARKED;
      end else if (pkt.seq > next_seq) begin
         r.status = srb_pkg::STAT_BEYOND;
      end else begin
         r.status = srb_pkg::STAT_DUPLICATE;
      end
      r.packets = packets_delivered;
      r.bytes   = bytes_delivered;

      n    = 1;
      slot = 32'(next_seq % srb_pkg::WINDOW);
      while (n < srb_pkg::MAX_RESULTS && parked_valid[slot]) begin
         expected_rsp_q.push_back(r);
         r.status = srb_pkg::STAT_DELIVERED;
         r.seq    = next_seq;
         r.len    = parked_len[slot];
         r.tag    = parked_tag[slot];
         parked_valid[slot] = 1'b0;
         packets_delivered += 1;
         bytes_delivered   += r.len;
         next_seq          += 1;
         r.packets = packets_delivered;
         r.bytes   = bytes_delivered;
         n++;
         slot = 32'(next_seq % srb_pkg::WINDOW);
      end
      r.last = 1'b1;
      expected_rsp_q.push_back(r);
   endfunction

   // Sender: advance to the next pending descriptor once the current transfer
   // is done; hold tvalid and tdata steady while the block stalls.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap > 0 || pending_q.size() == 0) begin
            req_tvalid <= 1'b0;
            if (req_gap > 0)
               req_gap <= req_gap - 1;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_q.pop_front();
            req_gap    <= pick_gap(req_steady);
            if (req_mode_left == 0) begin
               req_steady    <= ($urandom_range(0, 2) == 0);
               req_mode_left <= $urandom_range(20, 60);
            end else begin
               req_mode_left <= req_mode_left - 1;
            end
         end
      end
   end

   // Receiver: random stalls, stretches with none, and the long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_mode_left == 0) begin
            rsp_steady    <= ($urandom_range(0, 2) == 0);
            rsp_mode_left <= $urandom_range(50, 300);
         end else begin
            rsp_mode_left <= rsp_mode_left - 1;
         end
         if (hold_off) begin
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall  <= rsp_stall - 1;
         end else begin
            rsp_tready <= 1'b1;
            rsp_stall  <= pick_gap(rsp_steady);
         end
      end
   end

   // Monitor: predict on each accepted descriptor, check each result transfer.
   always @(posedge clock) begin
      srb_pkg::rsp_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            reorder_packet(req_tdata);
            accepted_count <= accepted_count + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp_q.size() == 0) begin
               report_error($sformatf("unexpected result, seq %h", rsp_tdata[63:0]));
            end else begin
               want = expected_rsp_q.pop_front();
               compare_field("status", 64'(rsp_tuser), 64'(want.status));
               compare_field("out_seq", rsp_tdata[63:0], want.seq);
               compare_field("out_length", 64'(rsp_tdata[79:64]), 64'(want.len));
               compare_field("out_tag", 64'(rsp_tdata[95:80]), 64'(want.tag));
               compare_field("delivered_packets", rsp_tdata[159:96], want.packets);
               compare_field("delivered_bytes", rsp_tdata[223:160], want.bytes);
               compare_field("last", 64'(rsp_tlast), 64'(want.last));
            end
         end
      end
   end

   // Back-pressure: block the result side long enough that the block fills up
   // and drops req_tready while the sender keeps offering.
   initial begin
      while (reset) @(posedge clock);
      while (accepted_count < 120) @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      #(64'd16_000_000);
      $display("sequence_reorder_buffer: mismatch");
      $finish;
   end

   initial begin
      pkt_desc_type              block [$];
      pkt_desc_type              pkt;
      logic [srb_pkg::SEQ_W-1:0] gen_next;
      int                        directed_count;
      int                        n, j, k, mode;

      next_seq          = '0;
      packets_delivered = '0;
      bytes_delivered   = '0;
      foreach (parked_valid[i])
         parked_valid[i] = 1'b0;

      // Directed: extremes, window edges, overwrite of a parked copy, drain.
      queue_packet(64'd0, 16'h0000, 16'h0000);               // in order from reset
      queue_packet(64'd0, 16'hFFFF, 16'hFFFF);               // older: duplicate
      queue_packet('1, 16'h1234, 16'h5678);                  // far ahead
      queue_packet(64'd1 + srb_pkg::WINDOW, 16'h0001, 16'h8000); // exactly one window ahead
      queue_packet(64'd0 + srb_pkg::WINDOW, 16'h8000, 16'h0001); // last slot inside window
      queue_packet(64'd3, 16'h0100, 16'h0003);
      queue_packet(64'd2, 16'h0200, 16'h0002);
      queue_packet(64'd3, 16'hABCD, 16'h3333);               // repeat replaces parked 3
      queue_packet(64'd1, 16'hFFFF, 16'hFFFF);               // delivers 1, releases 2 and 3
      queue_packet(64'd2, 16'h0002, 16'h0200);               // already released
      queue_packet(64'h8000_0000_0000_0000, 16'h00FF, 16'hFF00);
      queue_packet(64'h5555_5555_5555_5555, 16'h5555, 16'hAAAA);
      queue_packet(64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA, 16'h5555);
      queue_packet(64'd4, 16'h7FFF, 16'hFFFE);
      directed_count = pending_q.size();

      // Random: mostly runs of consecutive sequences in shuffled order, some
      // full-window runs with the head last, plus duplicates, far-ahead packets
      // and stray parks.
      gen_next = 64'd5;
      while (pending_q.size() < directed_count + RANDOM_ITEMS) begin
         mode = $urandom_range(0, 19);
         if (mode < 3) begin
            case ($urandom_range(0, 3))
               0:       queue_packet({$urandom, $urandom}, pick_field16(), pick_field16());
               1:       queue_packet(gen_next + srb_pkg::WINDOW + $urandom_range(0, 200),
                                     pick_field16(), pick_field16());
               2:       queue_packet(gen_next - $urandom_range(1, 40),
                                     pick_field16(), pick_field16());
               default: queue_packet(gen_next + $urandom_range(1, srb_pkg::WINDOW - 1),
                                     pick_field16(), pick_field16());
            endcase
         end else begin
            if (mode == 3)
               n = srb_pkg::WINDOW;
            else if (mode < 7)
               n = $urandom_range(13, srb_pkg::WINDOW - 1);
            else
               n = $urandom_range(1, 12);
            block.delete();
            for (j = 0; j < n; j++)
               block.push_back({pick_field16(), pick_field16(), gen_next + 64'(j)});
            if (mode == 3) begin
               // Park the whole window first, then release it in one burst.
               pkt = block[0]; block[0] = block[n-1]; block[n-1] = pkt;
            end else begin
               for (j = n - 1; j > 0; j--) begin
                  k = $urandom_range(0, j);
                  pkt = block[j]; block[j] = block[k]; block[k] = pkt;
               end
            end
            for (j = 0; j < n; j++) begin
               pending_q.push_back(block[j]);
               if ($urandom_range(0, 9) == 0) begin
                  pkt     = block[$urandom_range(0, j)];
                  pkt.len = pick_field16();
                  pkt.tag = pick_field16();
                  pending_q.push_back(pkt);
               end
            end
            gen_next += 64'(n);
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_tvalid) @(negedge clock);
      while (expected_rsp_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0)
         $display("sequence_reorder_buffer: match");
      else
         $display("sequence_reorder_buffer: mismatch");
      $finish;
   end

endmodule
